FILE: rtl/core/fffc_pkg.sv
// Shared widths, codes and the front-to-back transfer type of the FAT free cluster counter.
package fffc_pkg;

	localparam int BYTE_W      = 8;
	localparam int ENTRY_W     = 28;
	localparam int PART_W      = 24;
	localparam int PHASE_W     = 2;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 3;
	localparam int FMT_W       = 2;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Table entry formats; the unused code behaves as thirty-two-bit
	localparam logic [FMT_W-1:0] FMT_12 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_16 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_32 = 2'd2;

	// Register select taken from the word address bit
	localparam logic REG_TABLE_TYPE  = 1'b0;
	localparam logic REG_ENTRY_LIMIT = 1'b1;

	// One classified table byte handed from front to back
	typedef struct packed {
		logic start;      // byte opens a new table
		logic is_last;    // byte closes the table stream
		logic entry_done; // byte completes an entry
		logic entry_free; // completed entry is zero
	} fffc_op_t;

endpackage

FILE: rtl/core/fffc_front.sv
// Front end: accepts table bytes and assembles them into entries.
module fffc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [fffc_pkg::FMT_W-1:0]   table_type,
	input  logic [fffc_pkg::BYTE_W-1:0]  table_byte,
	input  logic                         first_byte,
	input  logic                         final_byte,
	input  logic                         accept,
	output fffc_pkg::fffc_op_t           op
);
	import fffc_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [PART_W-1:0]  partial_q;
	logic [PHASE_W-1:0] ph;
	logic [PART_W-1:0]  part;
	logic [PHASE_W-1:0] phase_nxt;
	logic [PART_W-1:0]  partial_nxt;
	logic               done;
	logic               free;

	// Assemble the byte into the current entry group
	always_comb begin
		ph          = first_byte ? '0 : phase_q;
		part        = first_byte ? '0 : partial_q;
		phase_nxt   = ph;
		partial_nxt = part;
		done        = 1'b0;
		free        = 1'b0;
		unique case (table_type)
			FMT_12: begin
				unique case (ph)
					2'd0: begin
						partial_nxt = {16'b0, table_byte};
						phase_nxt   = 2'd1;
					end
					2'd1: begin
						partial_nxt = {8'b0, table_byte, part[7:0]};
						done        = 1'b1;
						free        = (part[7:0] == 8'd0) && (table_byte[3:0] == 4'd0);
						phase_nxt   = 2'd2;
					end
					default: begin
						// odd entry: high nibble of middle byte plus this byte
						done        = 1'b1;
						free        = (part[15:12] == 4'd0) && (table_byte == 8'd0);
						partial_nxt = '0;
						phase_nxt   = 2'd0;
					end
				endcase
			end
			FMT_16: begin
				if (!ph[0]) begin
					partial_nxt = {16'b0, table_byte};
					phase_nxt   = 2'd1;
				end else begin
					done        = 1'b1;
					free        = (part[7:0] == 8'd0) && (table_byte == 8'd0);
					partial_nxt = '0;
					phase_nxt   = 2'd0;
				end
			end
			default: begin
				unique case (ph)
					2'd0: begin
						partial_nxt = {16'b0, table_byte};
						phase_nxt   = 2'd1;
					end
					2'd1: begin
						partial_nxt = {part[23:16], table_byte, part[7:0]};
						phase_nxt   = 2'd2;
					end
					2'd2: begin
						partial_nxt = {table_byte, part[15:0]};
						phase_nxt   = 2'd3;
					end
					default: begin
						// top nibble of the last byte is reserved
						done        = 1'b1;
						free        = (part == '0) && (table_byte[3:0] == 4'd0);
						partial_nxt = '0;
						phase_nxt   = 2'd0;
					end
				endcase
			end
		endcase
	end

	// Advance assembly state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			partial_q <= '0;
		end else if (accept) begin
			phase_q   <= phase_nxt;
			partial_q <= partial_nxt;
		end
	end

	assign op.start      = first_byte;
	assign op.is_last    = final_byte;
	assign op.entry_done = done;
	assign op.entry_free = free;

endmodule

FILE: rtl/core/fffc_queue.sv
// Small queue of classified bytes between front and back.
module fffc_queue #(
	parameter int DEPTH = fffc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fffc_pkg::fffc_op_t push_op,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output fffc_pkg::fffc_op_t head_op
);
	import fffc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	fffc_op_t         slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head_op   = slots_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/fffc_back.sv
// Back end: counts examined and free entries and issues the result.
module fffc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fffc_pkg::ENTRY_W-1:0]  entry_limit,
	input  logic                          op_valid,
	input  fffc_pkg::fffc_op_t            op,
	output logic                          op_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fffc_pkg::ENTRY_W-1:0]  free_entries,
	output logic                          ended_early
);
	import fffc_pkg::*;

	logic [ENTRY_W-1:0] seen_q;
	logic [ENTRY_W-1:0] tally_q;
	logic               finished_q;
	logic               out_valid_q;
	logic [ENTRY_W-1:0] free_q;
	logic               early_q;

	logic [ENTRY_W-1:0] seen_b;
	logic [ENTRY_W-1:0] tally_b;
	logic               fin_b;
	logic               below;
	logic               counted;
	logic [ENTRY_W-1:0] seen_inc;
	logic [ENTRY_W-1:0] seen_nxt;
	logic [ENTRY_W-1:0] tally_nxt;
	logic               limit_hit;
	logic               result;

	// Take an operation unless it issues a result while the output slot is held
	assign op_pop = op_valid && (!out_valid_q || !out_stall || !result);

	// Count the entry and decide whether the table is done
	always_comb begin
		seen_b    = op.start ? '0 : seen_q;
		tally_b   = op.start ? '0 : tally_q;
		fin_b     = op.start ? 1'b0 : finished_q;
		below     = (seen_b < entry_limit);
		counted   = op.entry_done && below;
		seen_inc  = seen_b + 1'b1;
		seen_nxt  = counted ? seen_inc : seen_b;
		tally_nxt = (counted && op.entry_free) ? tally_b + 1'b1 : tally_b;
		limit_hit = !below || (counted && (seen_inc == entry_limit));
		result    = !fin_b && (limit_hit || op.is_last);
	end

	// Update counters on each popped operation until the table is finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			tally_q    <= '0;
			finished_q <= 1'b0;
		end else if (op_pop && !fin_b) begin
			seen_q     <= seen_nxt;
			tally_q    <= tally_nxt;
			finished_q <= result;
		end
	end

	// Hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_pop && result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && result) begin
			free_q  <= tally_nxt;
			early_q <= !limit_hit;
		end
	end

	assign out_valid    = out_valid_q;
	assign free_entries = free_q;
	assign ended_early  = early_q;

endmodule

FILE: rtl/core/fat_free_cluster_counter_core.sv
// Top level of the FAT free cluster counter: register port, front, queue and back.
// Counts zero entries of a FAT12/16/32 allocation table streamed one byte per
// transfer; table_type (0: 12-bit, 1: 16-bit, 2 or 3: 32-bit with the top four
// bits ignored) and entry_limit live at byte addresses 0 and 4. A byte with
// first_byte set starts a new table. One result comes out once entry_limit
// entries have been examined or at the byte marked final_byte, and later bytes
// are dropped until the next first_byte. One byte is taken every cycle while the
// queue has room; the byte ending the table passes through the queue, and the
// back registers its result. The front assembles entries, the queue of
// QUEUE_DEPTH slots decouples it from the back, whose output register lets bytes
// that give no result keep flowing while a result waits; a further result waits
// at the head of the queue, and input stalls once the queue is full.
module fat_free_cluster_counter_core #(
	parameter int QUEUE_DEPTH = fffc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fffc_pkg::ADDR_W-1:0]   paddr,
	input  logic [fffc_pkg::DATA_W-1:0]   pwdata,
	output logic [fffc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fffc_pkg::BYTE_W-1:0]   table_byte,
	input  logic                          first_byte,
	input  logic                          final_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fffc_pkg::ENTRY_W-1:0]  free_entries,
	output logic                          ended_early
);
	import fffc_pkg::*;

	logic [FMT_W-1:0]   table_type_q;
	logic [ENTRY_W-1:0] entry_limit_q;
	logic               reg_sel;
	logic               wr_en;
	logic               accept;
	logic               q_full;
	logic               q_valid;
	logic               q_pop;
	fffc_op_t           front_op;
	fffc_op_t           head_op;

	// Register select from the word address; byte lanes are ignored
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_type_q  <= FMT_12;
			entry_limit_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TABLE_TYPE:  table_type_q  <= pwdata[FMT_W-1:0];
				REG_ENTRY_LIMIT: entry_limit_q <= pwdata[ENTRY_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		unique case (reg_sel)
			REG_TABLE_TYPE:  prdata = {{(DATA_W-FMT_W){1'b0}}, table_type_q};
			REG_ENTRY_LIMIT: prdata = {{(DATA_W-ENTRY_W){1'b0}}, entry_limit_q};
			default:         prdata = '0;
		endcase
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	fffc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_type (table_type_q),
		.table_byte (table_byte),
		.first_byte (first_byte),
		.final_byte (final_byte),
		.accept     (accept),
		.op         (front_op)
	);

	fffc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_op   (front_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head_op   (head_op)
	);

	fffc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_limit  (entry_limit_q),
		.op_valid     (q_valid),
		.op           (head_op),
		.op_pop       (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.free_entries (free_entries),
		.ended_early  (ended_early)
	);

endmodule

FILE: rtl/core/fffc_checker.sv
// Port-level checks of the FAT free cluster counter, bound to the top level.
module fffc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [fffc_pkg::ADDR_W-1:0]   paddr,
	input logic [fffc_pkg::DATA_W-1:0]   pwdata,
	input logic [fffc_pkg::DATA_W-1:0]   prdata,
	input logic                          pready,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [fffc_pkg::ENTRY_W-1:0]  free_entries,
	input logic                          ended_early
);
	import fffc_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(free_entries) && $stable(ended_early))
		else $error("stalled result changed");

	// A limit write reads back on the next cycle
	a_limit_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_LIMIT
		|=> !(psel && !pwrite && paddr[2] == REG_ENTRY_LIMIT)
			|| prdata[ENTRY_W-1:0] == $past(pwdata[ENTRY_W-1:0]))
		else $error("entry limit readback mismatch");

	// A format write reads back on the next cycle
	a_type_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_TABLE_TYPE
		|=> !(psel && !pwrite && paddr[2] == REG_TABLE_TYPE)
			|| prdata == {{(DATA_W-FMT_W){1'b0}}, $past(pwdata[FMT_W-1:0])})
		else $error("table type readback mismatch");

	// Register bits above the entry width read as zero
	a_read_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[DATA_W-1:ENTRY_W] == '0)
		else $error("reserved register bits set");

endmodule

bind fat_free_cluster_counter_core fffc_checker u_fffc_checker (.*);
